// ----- src/chip8_pkg.sv -----
// Shared constants, codes and types for the CHIP-8 instruction executor.
package chip8_pkg;

  localparam int MEMORY_DEPTH  = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int MA_W  = $clog2(MEMORY_DEPTH);
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] OPC_CLS  = 16'h00e0;
  localparam logic [15:0] OPC_RET  = 16'h00ee;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_PIXEL = 2'd3
  } cmd_t;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'ha;
  localparam logic [3:0] GRP_JPV0 = 4'hb;
  localparam logic [3:0] GRP_RND  = 4'hc;
  localparam logic [3:0] GRP_DRW  = 4'hd;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'he;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RX   = 9'b000000010,
    S_RY   = 9'b000000100,
    S_EX   = 9'b000001000,
    S_FLAG = 9'b000010000,
    S_DRD  = 9'b000100000,
    S_DWR  = 9'b001000000,
    S_DFIN = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_t;

  typedef struct packed {
    logic       ok;
    logic       has_flag;
    logic       flag;
    logic [7:0] res;
  } alu_res_t;

endpackage

// ----- src/chip8_if.sv -----
// Request and response channel interfaces.
interface chip8_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] opcode;
  logic [7:0]  random_byte;
  logic [11:0] address;
  logic [7:0]  write_data;
  modport source(output valid, command, opcode, random_byte, address, write_data,
                 input ready);
  modport sink(input valid, command, opcode, random_byte, address, write_data,
               output ready);
endinterface

interface chip8_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [11:0] pc_value;
  logic        collision;
  logic        status;
  modport source(output valid, read_data, pc_value, collision, status,
                 input ready);
  modport sink(input valid, read_data, pc_value, collision, status,
               output ready);
endinterface

// ----- src/chip8_alu.sv -----
// 8xy arithmetic/logic group with flag.
module chip8_alu (
  input  logic [3:0]         op,
  input  logic [7:0]         vx,
  input  logic [7:0]         vy,
  output chip8_pkg::alu_res_t res
);

  logic [8:0] sum;

  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    res = '0;
    res.ok = 1'b1;
    unique case (op)
      chip8_pkg::ALU_MOV: res.res = vy;
      chip8_pkg::ALU_OR:  res.res = vx | vy;
      chip8_pkg::ALU_AND: res.res = vx & vy;
      chip8_pkg::ALU_XOR: res.res = vx ^ vy;
      chip8_pkg::ALU_ADD: begin
        res.res = sum[7:0];
        res.has_flag = 1'b1;
        res.flag = sum[8];
      end
      chip8_pkg::ALU_SUB: begin
        res.res = vx - vy;
        res.has_flag = 1'b1;
        res.flag = vx > vy;
      end
      chip8_pkg::ALU_SHR: begin
        res.res = {1'b0, vx[7:1]};
        res.has_flag = 1'b1;
        res.flag = vx[0];
      end
      chip8_pkg::ALU_RSB: begin
        res.res = vy - vx;
        res.has_flag = 1'b1;
        res.flag = vy > vx;
      end
      chip8_pkg::ALU_SHL: begin
        res.res = {vx[6:0], 1'b0};
        res.has_flag = 1'b1;
        res.flag = vx[7];
      end
      default: res.ok = 1'b0;
    endcase
  end

endmodule

// ----- src/chip8_instruction_executor_unit.sv -----
// CHIP-8 instruction executor: sequencer around register, stack, memory and frame RAMs.
//
//   channel  dir  payload
//   req      in   command, opcode, random_byte, address, write_data
//   rsp      out  read_data, pc_value, collision, status
//
// Each transaction passes RX, RY, EX and PUSH; 8xy ops with a flag add FLAG, and Dxyn
// adds DFIN after a DRD, DWR pair per sprite row (memory and frame row read, then frame row write).
// Register file, stack, memory and frame RAMs all have registered read ports.
// Reset clears registers and all frame row valid bits at once; no clearing pass.
// A result waits in the output register; a new request is taken once it has been loaded,
// and the sequencer holds in its last state while the output register is still full.
module chip8_instruction_executor_unit (
  input logic          clk,
  input logic          rst,
  chip8_req_if.sink    req,
  chip8_rsp_if.source  rsp
);

  chip8_pkg::state_t state;

  logic [1:0]  cmd_q;
  logic [15:0] op_q;
  logic [7:0]  rnd_q;
  logic [11:0] addr_q;
  logic [7:0]  wd_q;

  logic [11:0] pc;
  logic [11:0] idx;
  logic [chip8_pkg::SP_W-1:0] sp;
  logic        vf0;
  logic [7:0]  vx_q;
  logic [7:0]  vy_q;
  logic [3:0]  row;
  logic        hit;
  logic        flag_q;
  logic        status_q;
  logic [7:0]  rdata_q;

  // register file
  logic [7:0] rf_mem [16];
  logic [7:0] rf_q;
  logic [3:0] rf_ra;
  logic       rf_we;
  logic [3:0] rf_wa;
  logic [7:0] rf_wd;

  // main memory
  logic [7:0] mem [chip8_pkg::MEMORY_DEPTH];
  logic [7:0] mem_q;
  logic       mem_re;
  logic       mem_we;
  logic [chip8_pkg::MA_W-1:0] mem_a;

  // call stack
  logic [11:0] stk [chip8_pkg::STACK_DEPTH];
  logic [11:0] stk_q;
  logic        stk_we;

  // frame buffer, one word per screen row
  logic [chip8_pkg::SCREEN_WIDTH-1:0] fb [chip8_pkg::SCREEN_HEIGHT];
  logic [chip8_pkg::SCREEN_WIDTH-1:0] fb_q;
  logic [chip8_pkg::SCREEN_HEIGHT-1:0] fb_vld;
  logic        fb_vq;
  logic        fb_re;
  logic        fb_we;
  logic [chip8_pkg::ROW_W-1:0] fb_a;
  logic [chip8_pkg::SCREEN_WIDTH-1:0] fb_wd;
  logic [chip8_pkg::SCREEN_WIDTH-1:0] fb_cur;

  logic [3:0]  grp;
  logic [3:0]  fx;
  logic [3:0]  fy;
  logic [3:0]  fn;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] sprite_a;
  logic [chip8_pkg::ROW_W-1:0] py;
  logic [chip8_pkg::SCREEN_WIDTH-1:0] m0;
  logic [2*chip8_pkg::SCREEN_WIDTH-1:0] mdbl;
  logic [chip8_pkg::SCREEN_WIDTH-1:0] mask;
  logic [chip8_pkg::SP_W-1:0] sp_dec;
  logic        out_free;
  logic        bad_op;
  chip8_pkg::state_t ex_state_next;

  chip8_pkg::alu_res_t alu;

  assign grp = op_q[15:12];
  assign fx  = op_q[11:8];
  assign fy  = op_q[7:4];
  assign fn  = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign sp_dec = sp - 1'b1;
  assign out_free = !rsp.valid || rsp.ready;

  assign sprite_a = idx + {8'd0, row};
  assign py = vy_q[chip8_pkg::ROW_W-1:0] + {1'b0, row};
  assign fb_cur = fb_vq ? fb_q : '0;

  always_comb begin
    m0 = '0;
    for (int c = 0; c < 8; c++) begin
      m0[c] = mem_q[7-c];
    end
  end

  // rotate sprite bits to the column, wrapping around the row
  assign mdbl = {m0, m0} << vx_q[chip8_pkg::COL_W-1:0];
  assign mask = mdbl[2*chip8_pkg::SCREEN_WIDTH-1:chip8_pkg::SCREEN_WIDTH];

  chip8_alu u_alu (
    .op (fn),
    .vx (vx_q),
    .vy (rf_q),
    .res(alu)
  );

  assign req.ready = (state == chip8_pkg::S_IDLE);

  // opcode check and follow-on state for an executed instruction
  always_comb begin
    bad_op = 1'b0;
    ex_state_next = chip8_pkg::S_PUSH;
    unique case (grp)
      chip8_pkg::GRP_SER, chip8_pkg::GRP_SNER: bad_op = (fn != 4'h0);
      chip8_pkg::GRP_ALU: begin
        bad_op = !alu.ok;
        if (alu.ok && alu.has_flag) begin
          ex_state_next = chip8_pkg::S_FLAG;
        end
      end
      chip8_pkg::GRP_DRW:
        ex_state_next = (fn == 4'h0) ? chip8_pkg::S_DFIN : chip8_pkg::S_DRD;
      chip8_pkg::GRP_SYS, chip8_pkg::GRP_JP, chip8_pkg::GRP_CALL, chip8_pkg::GRP_SE,
      chip8_pkg::GRP_SNE, chip8_pkg::GRP_LD, chip8_pkg::GRP_ADD, chip8_pkg::GRP_LDI,
      chip8_pkg::GRP_JPV0, chip8_pkg::GRP_RND: ;
      default: bad_op = 1'b1;
    endcase
  end

  // memory port control
  always_comb begin
    rf_ra  = fx;
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_a  = addr_q[chip8_pkg::MA_W-1:0];
    fb_re  = 1'b0;
    fb_we  = 1'b0;
    fb_a   = addr_q[chip8_pkg::ROW_W+chip8_pkg::COL_W-1:chip8_pkg::COL_W];
    fb_wd  = fb_cur ^ mask;
    unique case (state)
      chip8_pkg::S_RX: begin
        rf_ra  = (grp == chip8_pkg::GRP_JPV0) ? 4'h0 : fx;
        mem_we = (cmd_q == chip8_pkg::CMD_WRITE);
        mem_re = (cmd_q == chip8_pkg::CMD_READ);
        fb_re  = (cmd_q == chip8_pkg::CMD_PIXEL);
      end
      chip8_pkg::S_RY: rf_ra = fy;
      chip8_pkg::S_DRD: begin
        mem_re = 1'b1;
        mem_a  = sprite_a[chip8_pkg::MA_W-1:0];
        fb_re  = 1'b1;
        fb_a   = py;
      end
      chip8_pkg::S_DWR: begin
        fb_we = 1'b1;
        fb_a  = py;
      end
      default: ;
    endcase
  end

  // register file write port
  always_comb begin
    rf_we = 1'b0;
    rf_wa = fx;
    rf_wd = alu.res;
    unique case (state)
      chip8_pkg::S_EX: begin
        if (cmd_q == chip8_pkg::CMD_EXEC) begin
          unique case (grp)
            chip8_pkg::GRP_LD: begin
              rf_we = 1'b1;
              rf_wd = kk;
            end
            chip8_pkg::GRP_ADD: begin
              rf_we = 1'b1;
              rf_wd = vx_q + kk;
            end
            chip8_pkg::GRP_RND: begin
              rf_we = 1'b1;
              rf_wd = rnd_q & kk;
            end
            chip8_pkg::GRP_ALU: rf_we = alu.ok;
            default: ;
          endcase
        end
      end
      chip8_pkg::S_FLAG: begin
        rf_we = 1'b1;
        rf_wa = 4'hf;
        rf_wd = {7'd0, flag_q};
      end
      chip8_pkg::S_DFIN: begin
        rf_we = 1'b1;
        rf_wa = 4'hf;
        rf_wd = {7'd0, hit};
      end
      default: ;
    endcase
  end

  assign stk_we = (state == chip8_pkg::S_EX) && (cmd_q == chip8_pkg::CMD_EXEC)
                  && (grp == chip8_pkg::GRP_CALL);

  always_ff @(posedge clk) begin
    rf_q <= rf_mem[rf_ra];
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        rf_mem[i] <= '0;
      end
    end else if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_a];
    end
    if (mem_we) begin
      mem[mem_a] <= wd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == chip8_pkg::S_RX) begin
      stk_q <= stk[sp_dec];
    end
    if (stk_we) begin
      stk[sp] <= pc;
    end
  end

  always_ff @(posedge clk) begin
    if (fb_re) begin
      fb_q  <= fb[fb_a];
      fb_vq <= fb_vld[fb_a];
    end
    if (fb_we) begin
      fb[fb_a] <= fb_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chip8_pkg::S_IDLE;
      pc        <= chip8_pkg::PC_RESET;
      idx       <= '0;
      sp        <= '0;
      vf0       <= 1'b0;
      fb_vld    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != chip8_pkg::S_PUSH) begin
        rsp.valid <= 1'b0;
      end
      if (rf_we && rf_wa == 4'hf) begin
        vf0 <= rf_wd[0];
      end
      if (fb_we) begin
        fb_vld[fb_a] <= 1'b1;
      end
      unique case (state)
        chip8_pkg::S_IDLE: begin
          if (req.valid) begin
            cmd_q  <= req.command;
            op_q   <= req.opcode;
            rnd_q  <= req.random_byte;
            addr_q <= req.address;
            wd_q   <= req.write_data;
            state  <= chip8_pkg::S_RX;
          end
        end
        chip8_pkg::S_RX: state <= chip8_pkg::S_RY;
        chip8_pkg::S_RY: begin
          vx_q  <= rf_q;
          state <= chip8_pkg::S_EX;
        end
        chip8_pkg::S_EX: begin
          vy_q <= rf_q;
          row  <= '0;
          hit  <= 1'b0;
          case (cmd_q)
            chip8_pkg::CMD_READ: begin
              rdata_q  <= mem_q;
              status_q <= 1'b0;
              state    <= chip8_pkg::S_PUSH;
            end
            chip8_pkg::CMD_PIXEL: begin
              rdata_q  <= {7'd0, !addr_q[11] && fb_vq && fb_q[addr_q[chip8_pkg::COL_W-1:0]]};
              status_q <= 1'b0;
              state    <= chip8_pkg::S_PUSH;
            end
            chip8_pkg::CMD_EXEC: begin
              rdata_q  <= '0;
              status_q <= bad_op;
              state    <= ex_state_next;
              unique case (grp)
                chip8_pkg::GRP_SYS: begin
                  if (op_q == chip8_pkg::OPC_RET) begin
                    sp <= sp_dec;
                    pc <= stk_q + 12'd2;
                  end else begin
                    if (op_q == chip8_pkg::OPC_CLS) begin
                      fb_vld <= '0;
                    end
                    pc <= pc + 12'd2;
                  end
                end
                chip8_pkg::GRP_JP: pc <= nnn;
                chip8_pkg::GRP_CALL: begin
                  sp <= sp + 1'b1;
                  pc <= nnn;
                end
                chip8_pkg::GRP_SE:  pc <= pc + ((vx_q == kk) ? 12'd4 : 12'd2);
                chip8_pkg::GRP_SNE: pc <= pc + ((vx_q != kk) ? 12'd4 : 12'd2);
                chip8_pkg::GRP_SER, chip8_pkg::GRP_SNER: begin
                  if (fn == 4'h0) begin
                    if ((vx_q == rf_q) == (grp == chip8_pkg::GRP_SER)) begin
                      pc <= pc + 12'd4;
                    end else begin
                      pc <= pc + 12'd2;
                    end
                  end
                end
                chip8_pkg::GRP_LD, chip8_pkg::GRP_ADD, chip8_pkg::GRP_RND:
                  pc <= pc + 12'd2;
                chip8_pkg::GRP_ALU: begin
                  if (alu.ok) begin
                    pc     <= pc + 12'd2;
                    flag_q <= alu.flag;
                  end
                end
                chip8_pkg::GRP_LDI: begin
                  idx <= nnn;
                  pc  <= pc + 12'd2;
                end
                chip8_pkg::GRP_JPV0: pc <= nnn + {4'd0, vx_q};
                default: ;
              endcase
            end
            default: begin
              rdata_q  <= '0;
              status_q <= 1'b0;
              state    <= chip8_pkg::S_PUSH;
            end
          endcase
        end
        chip8_pkg::S_FLAG: state <= chip8_pkg::S_PUSH;
        chip8_pkg::S_DRD:  state <= chip8_pkg::S_DWR;
        chip8_pkg::S_DWR: begin
          hit <= hit | (|(fb_cur & mask));
          row <= row + 4'd1;
          state <= (row + 4'd1 == fn) ? chip8_pkg::S_DFIN : chip8_pkg::S_DRD;
        end
        chip8_pkg::S_DFIN: begin
          pc    <= pc + 12'd2;
          state <= chip8_pkg::S_PUSH;
        end
        chip8_pkg::S_PUSH: begin
          if (out_free) begin
            rsp.valid     <= 1'b1;
            rsp.read_data <= rdata_q;
            rsp.pc_value  <= pc;
            rsp.collision <= vf0;
            rsp.status    <= status_q;
            state         <= chip8_pkg::S_IDLE;
          end
        end
        default: state <= chip8_pkg::S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rsp_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == chip8_pkg::S_PUSH))
    else $error("response raised outside push state");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == chip8_pkg::S_DWR) |-> (row < fn))
    else $error("sprite row beyond height");

  a_fb_write: assert property (@(posedge clk) disable iff (rst)
    fb_we |-> $past(state == chip8_pkg::S_DRD))
    else $error("frame write without preceding row read");

  a_pc_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (pc == chip8_pkg::PC_RESET && sp == '0))
    else $error("pc or sp not at reset value");
`endif

endmodule

// ----- tb/chip8_tb_if.sv -----
// Testbench package: snapshot type for one response transaction.
`timescale 1ns / 100ps
package chip8_tb_pkg;
  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] pc_value;
    logic        collision;
    logic        status;
  } chip8_result_t;
endpackage

// ----- tb/chip8_checker.sv -----
// Checker: watches request and response channels, predicts CHIP-8 results and compares them.
`timescale 1ns / 100ps
module chip8_checker (
  input  logic      clk,
  input  logic      rst,
  chip8_req_if.sink req_mon,
  chip8_rsp_if.sink rsp_mon,
  output int        fail_count,
  output int        pending
);
  logic [7:0]  vreg [16];
  logic [11:0] ireg;
  logic [11:0] pc;
  logic [3:0]  sp;
  logic [11:0] stk [chip8_pkg::STACK_DEPTH];
  logic [7:0]  mem [chip8_pkg::MEMORY_DEPTH];
  logic        fb [chip8_pkg::SCREEN_WIDTH*chip8_pkg::SCREEN_HEIGHT];
  chip8_tb_pkg::chip8_result_t expected_results[$];

  function automatic logic exec_opcode(logic [15:0] op, logic [7:0] rnd);
    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy, res;
    logic [8:0] sum;
    logic flag, hit, has_flag;
    logic [7:0] bits;
    int ox, oy, p;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
    vx = vreg[x]; vy = vreg[y];
    case (op[15:12])
      chip8_pkg::GRP_SYS: begin
        if (op == chip8_pkg::OPC_CLS) begin
          foreach (fb[i]) fb[i] = 1'b0;
          pc = pc + 12'd2;
        end else if (op == chip8_pkg::OPC_RET) begin
          sp = sp - 4'd1;
          pc = stk[sp] + 12'd2;
        end else pc = pc + 12'd2;
      end
      chip8_pkg::GRP_JP: pc = op[11:0];
      chip8_pkg::GRP_CALL: begin
        stk[sp] = pc; sp = sp + 4'd1; pc = op[11:0];
      end
      chip8_pkg::GRP_SE: pc = pc + ((vx == kk) ? 12'd4 : 12'd2);
      chip8_pkg::GRP_SNE: pc = pc + ((vx != kk) ? 12'd4 : 12'd2);
      chip8_pkg::GRP_SER: begin
        if (n != 4'h0) return 1'b0;
        pc = pc + ((vx == vy) ? 12'd4 : 12'd2);
      end
      chip8_pkg::GRP_LD: begin vreg[x] = kk; pc = pc + 12'd2; end
      chip8_pkg::GRP_ADD: begin vreg[x] = vx + kk; pc = pc + 12'd2; end
      chip8_pkg::GRP_ALU: begin
        has_flag = 1'b1; flag = 1'b0;
        case (n)
          chip8_pkg::ALU_MOV: begin res = vy; has_flag = 1'b0; end
          chip8_pkg::ALU_OR:  begin res = vx | vy; has_flag = 1'b0; end
          chip8_pkg::ALU_AND: begin res = vx & vy; has_flag = 1'b0; end
          chip8_pkg::ALU_XOR: begin res = vx ^ vy; has_flag = 1'b0; end
          chip8_pkg::ALU_ADD: begin sum = vx + vy; res = sum[7:0]; flag = sum[8]; end
          chip8_pkg::ALU_SUB: begin res = vx - vy; flag = vx > vy; end
          chip8_pkg::ALU_SHR: begin res = vx >> 1; flag = vx[0]; end
          chip8_pkg::ALU_RSB: begin res = vy - vx; flag = vy > vx; end
          chip8_pkg::ALU_SHL: begin res = vx << 1; flag = vx[7]; end
          default: return 1'b0;
        endcase
        vreg[x] = res;
        if (has_flag) vreg[15] = {7'd0, flag};
        pc = pc + 12'd2;
      end
      chip8_pkg::GRP_SNER: begin
        if (n != 4'h0) return 1'b0;
        pc = pc + ((vx != vy) ? 12'd4 : 12'd2);
      end
      chip8_pkg::GRP_LDI: begin ireg = op[11:0]; pc = pc + 12'd2; end
      chip8_pkg::GRP_JPV0: pc = op[11:0] + {4'd0, vreg[0]};
      chip8_pkg::GRP_RND: begin vreg[x] = rnd & kk; pc = pc + 12'd2; end
      chip8_pkg::GRP_DRW: begin
        ox = vx % chip8_pkg::SCREEN_WIDTH; oy = vy % chip8_pkg::SCREEN_HEIGHT; hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          bits = mem[(ireg + r) % chip8_pkg::MEMORY_DEPTH];
          for (int c = 0; c < 8; c++)
            if (bits[7-c]) begin
              p = ((oy + r) % chip8_pkg::SCREEN_HEIGHT) * chip8_pkg::SCREEN_WIDTH
                  + (ox + c) % chip8_pkg::SCREEN_WIDTH;
              if (fb[p]) hit = 1'b1;
              fb[p] = ~fb[p];
            end
        end
        vreg[15] = {7'd0, hit};
        pc = pc + 12'd2;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic chip8_tb_pkg::chip8_result_t predict_result(chip8_pkg::cmd_t cmd,
      logic [15:0] op, logic [7:0] rnd, logic [11:0] addr, logic [7:0] wdata);
    chip8_tb_pkg::chip8_result_t r;
    r = '0;
    case (cmd)
      chip8_pkg::CMD_EXEC:  r.status = ~exec_opcode(op, rnd);
      chip8_pkg::CMD_WRITE: mem[addr] = wdata;
      chip8_pkg::CMD_READ:  r.read_data = mem[addr];
      default: r.read_data = (addr < chip8_pkg::SCREEN_WIDTH*chip8_pkg::SCREEN_HEIGHT)
                             ? {7'd0, fb[addr]} : 8'd0;
    endcase
    r.pc_value = pc;
    r.collision = vreg[15][0];
    return r;
  endfunction

  always @(posedge clk) begin
    chip8_tb_pkg::chip8_result_t exp_r;
    if (rst) begin
      foreach (vreg[i]) vreg[i] = '0;
      foreach (fb[i]) fb[i] = 1'b0;
      foreach (stk[i]) stk[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      ireg = '0; pc = chip8_pkg::PC_RESET; sp = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected response transaction");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (rsp_mon.read_data !== exp_r.read_data) begin
            $error("read_data expected %0h got %0h", exp_r.read_data, rsp_mon.read_data);
            fail_count++;
          end
          if (rsp_mon.pc_value !== exp_r.pc_value) begin
            $error("pc_value expected %0h got %0h", exp_r.pc_value, rsp_mon.pc_value);
            fail_count++;
          end
          if (rsp_mon.collision !== exp_r.collision) begin
            $error("collision expected %0b got %0b", exp_r.collision, rsp_mon.collision);
            fail_count++;
          end
          if (rsp_mon.status !== exp_r.status) begin
            $error("status expected %0b got %0b", exp_r.status, rsp_mon.status);
            fail_count++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(predict_result(chip8_pkg::cmd_t'(req_mon.command),
            req_mon.opcode, req_mon.random_byte, req_mon.address, req_mon.write_data));
    end
    pending = expected_results.size();
  end
endmodule

// ----- tb/testbench.sv -----
// Top: stimulus for the CHIP-8 executor, response back-pressure and final verdict.
`timescale 1ns / 100ps
module testbench;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_rsp;
  int   stall_cycles;
  logic [11:0] mem_written[$];
  bit   written [chip8_pkg::MEMORY_DEPTH];
  int   depth;

  chip8_req_if req();
  chip8_rsp_if rsp();

  chip8_instruction_executor_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  chip8_checker checker_i (.clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
                           .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] op, logic [7:0] rnd,
                           logic [11:0] addr, logic [7:0] wdata);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.command <= cmd; req.opcode <= op; req.random_byte <= rnd;
    req.address <= addr; req.write_data <= wdata;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (cmd == chip8_pkg::CMD_WRITE && !written[addr]) begin
      written[addr] = 1'b1;
      mem_written.push_back(addr);
    end
  endtask

  task automatic write_byte(logic [11:0] addr, logic [7:0] d);
    send_item(chip8_pkg::CMD_WRITE, 16'($urandom), 8'($urandom), addr, d);
  endtask

  task automatic exec_op(logic [15:0] op);
    send_item(chip8_pkg::CMD_EXEC, op, 8'($urandom), 12'($urandom), 8'($urandom));
  endtask

  function automatic logic [11:0] known_addr();
    return mem_written[$urandom_range(mem_written.size() - 1)];
  endfunction

  // random opcode that never reads an unwritten stack entry or memory byte
  task automatic random_exec();
    logic [15:0] op;
    logic [3:0]  grp;
    op = 16'($urandom);
    grp = op[15:12];
    if (grp == chip8_pkg::GRP_SYS) begin
      case ($urandom_range(3))
        0: op = chip8_pkg::OPC_CLS;
        1: op = (depth > 0) ? chip8_pkg::OPC_RET : chip8_pkg::OPC_CLS;
        default: ;
      endcase
    end
    if (op == chip8_pkg::OPC_RET) begin
      if (depth == 0) op = chip8_pkg::OPC_CLS;
      else depth--;
    end
    if (grp == chip8_pkg::GRP_CALL && depth < chip8_pkg::STACK_DEPTH) depth++;
    else if (grp == chip8_pkg::GRP_CALL) op[15:12] = chip8_pkg::GRP_JP;
    if (grp == chip8_pkg::GRP_ALU && $urandom_range(3) != 0)
      op[3:0] = ($urandom_range(8) == 8) ? chip8_pkg::ALU_SHL : 4'($urandom_range(7));
    if ((grp == chip8_pkg::GRP_SER || grp == chip8_pkg::GRP_SNER) && $urandom_range(3) != 0)
      op[3:0] = 4'h0;
    if (grp == chip8_pkg::GRP_DRW) begin
      op[3:0] = 4'($urandom_range(4));
      if ($urandom_range(9) == 0) op[3:0] = 4'hf;
      // point I at a block of written bytes first
      exec_op({chip8_pkg::GRP_LDI, 12'h300 + 12'($urandom_range(7)) * 12'd16});
    end
    exec_op(op);
  endtask

  task automatic wait_drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [11:0] a;
    rst = 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    depth = 0;
    req.valid = 1'b0; req.command = '0; req.opcode = '0; req.random_byte = '0;
    req.address = '0; req.write_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, most opcode groups, special cases
    write_byte(12'h000, 8'h00);
    write_byte(12'hfff, 8'hff);
    send_item(chip8_pkg::CMD_READ, 16'hffff, 8'hff, 12'hfff, 8'h00);
    send_item(chip8_pkg::CMD_PIXEL, 16'h0000, 8'h00, 12'hfff, 8'hff);
    for (int i = 0; i < 128; i++) write_byte(12'h300 + 12'(i), 8'($urandom));
    exec_op(16'h60ff); exec_op(16'h61ff); exec_op(16'h8014);
    exec_op(16'h8015); exec_op(16'h8017); exec_op(16'h80f6); exec_op(16'h8ffe);
    exec_op(16'h8f08);  // unrecognized alu
    exec_op(16'h5011); exec_op(16'h9012); exec_op(16'hefff); exec_op(16'hf000);
    exec_op(16'h0123);  // system call
    exec_op(16'hafff); exec_op(16'h6f3f); exec_op(16'h6e1f);
    exec_op(16'hdfe2);  // wraps both axes and the memory address
    exec_op(16'hdfe2);  // collision
    send_item(chip8_pkg::CMD_PIXEL, '0, '0, 12'd2047, '0);
    exec_op(16'h00e0);
    for (int i = 0; i < chip8_pkg::STACK_DEPTH + 1; i++) exec_op(16'h2fff);  // overflow wrap
    for (int i = 0; i < chip8_pkg::STACK_DEPTH + 1; i++) exec_op(chip8_pkg::OPC_RET);
    exec_op(16'h60ff); exec_op(16'hbfff);  // offset jump wrap
    exec_op(16'hc0ff); exec_op(16'h30ff); exec_op(16'h40ff); exec_op(16'h1000);
    // sender pauses until everything is back
    wait_drain();

    for (int i = 0; i < 8; i++) random_exec();
    wait_drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 37 : 0;
      for (int i = 0; i < 65; i++) begin
        case ($urandom_range(9))
          0: begin
            a = 12'($urandom);
            if (a >= 12'h300 && a < 12'h380) a = a + 12'h100;
            write_byte(a, 8'($urandom));
          end
          1: send_item(chip8_pkg::CMD_READ, 16'($urandom), 8'($urandom), known_addr(),
                       8'($urandom));
          2: send_item(chip8_pkg::CMD_PIXEL, 16'($urandom), 8'($urandom), 12'($urandom),
                       8'($urandom));
          default: random_exec();
        endcase
      end
    end
    wait_drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // long receiver hold while the sender keeps offering
  initial begin
    int n;
    @(negedge rst);
    wait (send_idle_pct == 37);
    hold_rsp = 1'b1;
    n = 0;
    while (n < 300) begin
      @(posedge clk);
      n++;
    end
    hold_rsp = 1'b0;
  end
endmodule
